// File: src/tpag_pkg.sv
// Package for the tensor permute address generator.
// Types, register codes and fixed widths shared by all src files; no dependencies.
package tpag_pkg;

  // Fixed field and register widths
  localparam int OUT_W        = 24;
  localparam int AXIS_W       = 3;
  localparam int NUM_DIMS     = 6;
  localparam int ORDER_W      = 18;
  localparam int ORDER_FULL_W = 24;  // room for eight 3-bit axis codes
  localparam int RANK_W       = 3;
  localparam int DIM_REG_W    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_5      = 3'd7;

  // Register reset values (identity permutation, rank 6, unit sizes)
  localparam logic [RANK_W-1:0]    RANK_RST  = 3'd6;
  localparam logic [ORDER_W-1:0]   ORDER_RST = 18'd181896;
  localparam logic [DIM_REG_W-1:0] DIM_RST   = 16'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUF,
    ST_STR,
    ST_MAC,
    ST_FIN
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // transaction accepted on the input channel
    logic restart;   // accepted transaction carries restart
    logic suf_step;  // one suffix-product step at idx
    logic str_step;  // latch stride of output axis idx
    logic mac_step;  // multiply-accumulate of output axis idx
    logic fin;       // load result register, advance counters
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_status_t;

endpackage

// File: src/tensor_permute_address_gen.sv
// Tensor permute address generator: for each input transaction it returns, in destination
// order, the source offset of one element of a permuted row-major tensor, its linear
// destination index and a last flag; the pass wraps to element 0 after the last element.
// Timing depends on the rank in use (zero counts as one, saturated at MAX_RANK). A
// transaction without restart is accepted, then runs one multiply-accumulate per axis
// on the single shared multiplier, then a result load. A restart transaction first runs
// one suffix product per axis in use on that multiplier, then latches MAX_RANK strides.
// A finished result waits in an output register while the next transaction is taken. The
// result load stalls while that register still holds an unaccepted result. Configuration
// writes take effect at once; strides change only on restart.
// Depends on tpag_pkg, tpag_cfg, tpag_ctrl and tpag_dp.
module tensor_permute_address_gen import tpag_pkg::*; #(
  parameter int MAX_RANK  = 6,
  parameter int ADDR_BITS = 24,
  parameter int DIM_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_src_offset,
  output logic [OUT_W-1:0]      out_dst_index,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_RANK);
  localparam int RK_W  = $clog2(MAX_RANK + 1);

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [IDX_W-1:0]    idx;
  logic [RK_W-1:0]     er;
  logic [AXIS_W-1:0]   src_axis;
  logic [AXIS_W-1:0]   size_addr;
  logic [DIM_BITS-1:0] size_rd;

  // Configuration registers
  tpag_cfg #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .idx       (idx),
    .size_addr (size_addr),
    .er        (er),
    .src_axis  (src_axis),
    .size_rd   (size_rd)
  );

  // Sequencer
  tpag_ctrl #(
    .MAX_RANK (MAX_RANK)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_ready   (in_ready),
    .er         (er),
    .status     (status),
    .cmd        (cmd),
    .idx        (idx)
  );

  // Counters, strides and offset arithmetic
  tpag_dp #(
    .MAX_RANK  (MAX_RANK),
    .ADDR_BITS (ADDR_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .idx            (idx),
    .er             (er),
    .src_axis       (src_axis),
    .size_rd        (size_rd),
    .size_addr      (size_addr),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_src_offset (out_src_offset),
    .out_dst_index  (out_dst_index),
    .out_last       (out_last),
    .status         (status)
  );

endmodule

// File: src/tpag_cfg.sv
// Configuration register file of the tensor permute address generator.
// Depends on tpag_pkg; provides effective rank, axis lookup and size lookup.
module tpag_cfg import tpag_pkg::*; #(
  parameter int MAX_RANK = 6,
  parameter int DIM_BITS = 16,
  localparam int IDX_W = $clog2(MAX_RANK),
  localparam int RK_W  = $clog2(MAX_RANK + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IDX_W-1:0]      idx,
  input  logic [AXIS_W-1:0]     size_addr,
  output logic [RK_W-1:0]       er,
  output logic [AXIS_W-1:0]     src_axis,
  output logic [DIM_BITS-1:0]   size_rd
);

  logic [RANK_W-1:0]       rank_r;
  logic [ORDER_W-1:0]      order_r;
  logic [DIM_REG_W-1:0]    dim_r [NUM_DIMS];
  logic [CFG_IDX_W-1:0]    dim_sel;
  logic [ORDER_FULL_W-1:0] order_full;
  logic [DIM_BITS-1:0]     dim_masked;

  assign dim_sel = cfg_index - REG_DIM_0;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= RANK_RST;
      order_r <= ORDER_RST;
      for (int i = 0; i < NUM_DIMS; i++) begin
        dim_r[i] <= DIM_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_RANK:               rank_r         <= cfg_wdata[RANK_W-1:0];
        REG_AXIS_ORDER:         order_r        <= cfg_wdata;
        [REG_DIM_0:REG_DIM_5]:  dim_r[dim_sel] <= cfg_wdata[DIM_REG_W-1:0];
      endcase
    end
  end

  // Effective rank: zero reads as one, saturate at MAX_RANK
  always_comb begin
    if (rank_r == '0) begin
      er = RK_W'(1);
    end else if (int'(rank_r) > MAX_RANK) begin
      er = RK_W'(MAX_RANK);
    end else begin
      er = RK_W'(rank_r);
    end
  end

  // Source axis of output axis idx; codes past the register read as zero
  assign order_full = ORDER_FULL_W'(order_r);
  assign src_axis   = order_full[AXIS_W*idx +: AXIS_W];

  // Source size lookup; zero size and axes without a register read as one
  always_comb begin
    size_rd    = DIM_BITS'(1);
    dim_masked = '0;
    if (int'(size_addr) < NUM_DIMS) begin
      dim_masked = DIM_BITS'(dim_r[size_addr]);
      if (dim_masked != '0) begin
        size_rd = dim_masked;
      end
    end
  end

endmodule

// File: src/tpag_ctrl.sv
// Controller of the tensor permute address generator.
// Depends on tpag_pkg; sequences stride setup and the per-axis offset walk.
module tpag_ctrl import tpag_pkg::*; #(
  parameter int MAX_RANK = 6,
  localparam int IDX_W = $clog2(MAX_RANK),
  localparam int RK_W  = $clog2(MAX_RANK + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_restart,
  output logic             in_ready,
  input  logic [RK_W-1:0]  er,
  input  dp_status_t       status,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] idx
);

  ctrl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             er_last;
  logic             idx_max;

  assign idx      = idx_r;
  assign er_last  = (idx_r == IDX_W'(er - 1'b1));
  assign idx_max  = (idx_r == IDX_W'(MAX_RANK - 1));

  // State and axis index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start   = 1'b1;
          cmd.restart = in_restart;
          if (in_restart) begin
            idx_nxt   = IDX_W'(er - 1'b1);
            state_nxt = ST_SUF;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_MAC;
          end
        end
      end
      // suffix products, innermost source axis first
      ST_SUF: begin
        cmd.suf_step = 1'b1;
        if (idx_r == '0) begin
          state_nxt = ST_STR;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      // one stride per output axis
      ST_STR: begin
        cmd.str_step = 1'b1;
        if (idx_max) begin
          idx_nxt   = '0;
          state_nxt = ST_MAC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // offset accumulation over axes in use
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (er_last) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: src/tpag_dp.sv
// Datapath of the tensor permute address generator.
// Depends on tpag_pkg; holds counters, strides, the shared multiplier and the result register.
module tpag_dp import tpag_pkg::*; #(
  parameter int MAX_RANK  = 6,
  parameter int ADDR_BITS = 24,
  parameter int DIM_BITS  = 16,
  localparam int IDX_W = $clog2(MAX_RANK),
  localparam int RK_W  = $clog2(MAX_RANK + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic [IDX_W-1:0]     idx,
  input  logic [RK_W-1:0]      er,
  input  logic [AXIS_W-1:0]    src_axis,
  input  logic [DIM_BITS-1:0]  size_rd,
  output logic [AXIS_W-1:0]    size_addr,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_src_offset,
  output logic [OUT_W-1:0]     out_dst_index,
  output logic                 out_last,
  output dp_status_t           status
);

  logic [DIM_BITS-1:0]           cnt_r    [MAX_RANK];
  logic [DIM_BITS-1:0]           cnt_nxt  [MAX_RANK];
  logic [ADDR_BITS-1:0]          stride_r [MAX_RANK];
  logic [ADDR_BITS-1:0]          suf_r    [MAX_RANK];
  logic [DIM_BITS-1:0]           osz_r    [MAX_RANK];
  logic                          wrap     [MAX_RANK];
  logic [ADDR_BITS-1:0]          run_r;
  logic [ADDR_BITS-1:0]          prod_r;
  logic [ADDR_BITS-1:0]          acc_r;
  logic [ADDR_BITS-1:0]          dest_r;
  logic                          out_valid_r;
  logic [OUT_W-1:0]              out_off_r;
  logic [OUT_W-1:0]              out_dst_r;
  logic                          out_last_r;
  logic                          src_in_rank;
  logic                          axis_in_rank;
  logic [ADDR_BITS-1:0]          mul_a;
  logic [DIM_BITS-1:0]           mul_b;
  logic [ADDR_BITS+DIM_BITS-1:0] mul_full;
  logic [ADDR_BITS-1:0]          mul_lo;
  logic [DIM_BITS-1:0]           osz_cur;
  logic [ADDR_BITS-1:0]          stride_sel;
  logic [ADDR_BITS-1:0]          offset_sum;
  logic                          all_wrap;

  assign src_in_rank  = int'(src_axis) < int'(er);
  assign axis_in_rank = int'(idx) < int'(er);

  // Size lookup: source axis idx during suffix steps, else the permuted axis
  assign size_addr = cmd.suf_step ? AXIS_W'(idx) : src_axis;

  // Shared multiplier, truncated modulo 2^ADDR_BITS
  assign mul_a    = cmd.suf_step ? run_r : stride_r[idx];
  assign mul_b    = cmd.suf_step ? size_rd : cnt_r[idx];
  assign mul_full = mul_a * mul_b;
  assign mul_lo   = mul_full[ADDR_BITS-1:0];

  // Output axis size; an out-of-range source axis has size one and stride zero
  assign osz_cur    = src_in_rank ? size_rd : DIM_BITS'(1);
  assign stride_sel = (axis_in_rank && src_in_rank) ? suf_r[src_axis[IDX_W-1:0]] : '0;

  assign offset_sum = acc_r + prod_r;

  // Per-axis wrap detect; counters at or past their size carry
  always_comb begin
    for (int k = 0; k < MAX_RANK; k++) begin
      wrap[k] = ({1'b0, cnt_r[k]} + 1'b1) >= {1'b0, osz_r[k]};
    end
  end

  // Carry from innermost axis outward; full carry means last element
  always_comb begin
    all_wrap = 1'b1;
    for (int k = MAX_RANK - 1; k >= 0; k--) begin
      cnt_nxt[k] = cnt_r[k];
      if (k < int'(er)) begin
        if (all_wrap) begin
          cnt_nxt[k] = wrap[k] ? '0 : cnt_r[k] + 1'b1;
        end
        all_wrap = all_wrap & wrap[k];
      end
    end
  end

  // Control state: counters, strides, destination index, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        cnt_r[k]    <= '0;
        stride_r[k] <= '0;
      end
      dest_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start && cmd.restart) begin
        for (int k = 0; k < MAX_RANK; k++) begin
          cnt_r[k] <= '0;
        end
        dest_r <= '0;
      end
      if (cmd.str_step) begin
        stride_r[idx] <= stride_sel;
      end
      if (cmd.fin) begin
        for (int k = 0; k < MAX_RANK; k++) begin
          cnt_r[k] <= cnt_nxt[k];
        end
        dest_r      <= all_wrap ? '0 : dest_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r  <= '0;
      prod_r <= '0;
    end
    if (cmd.start && cmd.restart) begin
      run_r <= ADDR_BITS'(1);
    end
    if (cmd.suf_step) begin
      suf_r[idx] <= run_r;
      run_r      <= mul_lo;
    end
    if (cmd.mac_step) begin
      prod_r     <= mul_lo;
      acc_r      <= offset_sum;
      osz_r[idx] <= osz_cur;
    end
    if (cmd.fin) begin
      out_off_r  <= OUT_W'(offset_sum);
      out_dst_r  <= OUT_W'(dest_r);
      out_last_r <= all_wrap;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_src_offset  = out_off_r;
  assign out_dst_index   = out_dst_r;
  assign out_last        = out_last_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// File: src/tpag_checker.sv
// Port-level checks for the tensor permute address generator.
// Depends on tpag_pkg; bound to tensor_permute_address_gen below.
module tpag_checker import tpag_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_src_offset,
  input logic [OUT_W-1:0] out_dst_index,
  input logic             out_last
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_offset)
      && $stable(out_dst_index) && $stable(out_last))
    else $error("result changed while stalled");

  // One transaction in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  // Out of reset: idle, nothing pending
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("not idle after reset");

  // A new result only comes from a transaction in work
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in work");

endmodule

bind tensor_permute_address_gen tpag_checker u_tpag_checker (.*);

// File: tb/tb_tensor_permute_address_gen.sv
// Testbench for the tensor permute address generator: a directed table, then random
// configuration phases under three handshake idle mixes, checked against an in-bench predictor.
// Depends on tpag_pkg and the tensor_permute_address_gen RTL.
`timescale 1ns / 100ps

module tb_tensor_permute_address_gen;
  import tpag_pkg::*;

  localparam int          MAX_RANK     = 6;
  localparam int          ADDR_BITS    = 24;
  localparam int          DIM_BITS     = 16;
  localparam longint      ADDR_MASK    = (64'd1 << ADDR_BITS) - 1;
  localparam int          RANDOM_ITEMS = 650;
  localparam int          DRAIN_CYCLES = 2;
  localparam int          END_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int          DIR_ROWS     = 37;

  // One expected result
  typedef struct {
    logic [OUT_W-1:0] src_offset;
    logic [OUT_W-1:0] dst_index;
    logic             last;
  } addr_result_t;

  // Directed stimulus row: either a register write or a transaction
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  ridx;
    logic [CFG_DATA_W-1:0] wdata;
    bit                    restart;
    bit                    typed;
    logic [OUT_W-1:0]      off;
    logic [OUT_W-1:0]      dst;
    bit                    last;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_W-1:0]      out_src_offset;
  logic [OUT_W-1:0]      out_dst_index;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tensor_permute_address_gen #(
    .MAX_RANK (MAX_RANK),
    .ADDR_BITS(ADDR_BITS),
    .DIM_BITS (DIM_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_src_offset(out_src_offset),
    .out_dst_index (out_dst_index),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers and the address state
  logic [RANK_W-1:0]    cfg_rank_q  = RANK_RST;
  logic [ORDER_W-1:0]   cfg_order_q = ORDER_RST;
  logic [DIM_REG_W-1:0] cfg_dim_q [NUM_DIMS];
  logic [DIM_BITS-1:0]  ctr_q     [MAX_RANK];
  logic [OUT_W-1:0]     stride_q  [MAX_RANK];
  logic [OUT_W-1:0]     dst_q = '0;

  addr_result_t pending_addrs[$];

  int          send_idle = 0;
  int          recv_idle = 0;
  int          error_count = 0;
  int          items_sent = 0;
  int          restarts_sent = 0;
  int          results_checked = 0;
  int          last_seen = 0;
  int          reg_writes = 0;
  int unsigned cycle_count = 0;

  dir_row_t dir_table [DIR_ROWS];

  // Rank in use: zero counts as one, above the axis count saturates
  function automatic int unsigned active_rank();
    int unsigned r;
    r = cfg_rank_q;
    if (r == 0) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    return r;
  endfunction

  function automatic int unsigned axis_src(int unsigned i);
    return (cfg_order_q >> (3 * i)) & 3'h7;
  endfunction

  // Source size with a zero size read as one
  function automatic longint unsigned src_dim(int unsigned a);
    longint unsigned d;
    d = cfg_dim_q[a];
    return (d == 0) ? 1 : d;
  endfunction

  // Output axis size; an out-of-range source axis gives size one
  function automatic longint unsigned axis_size(int unsigned i, int unsigned er);
    int unsigned a;
    a = axis_src(i);
    if (a >= er) return 1;
    return src_dim(a);
  endfunction

  // Emit the current element, then advance the counters
  function automatic addr_result_t next_address(bit restart);
    addr_result_t    res;
    int unsigned     er;
    int unsigned     a;
    int unsigned     i;
    int unsigned     j;
    int              k;
    longint unsigned s;
    longint unsigned off;
    bit              is_last;
    bit              carry;
    er = active_rank();
    if (restart) begin
      for (i = 0; i < MAX_RANK; i++) begin
        s = 0;
        a = axis_src(i);
        if (i < er && a < er) begin
          s = 1;
          for (j = a + 1; j < er; j++) s = (s * src_dim(j)) & ADDR_MASK;
        end
        stride_q[i] = s[OUT_W-1:0];
        ctr_q[i] = '0;
      end
      dst_q = '0;
    end
    off = 0;
    is_last = 1'b1;
    for (i = 0; i < er; i++) begin
      off = (off + longint'(ctr_q[i]) * longint'(stride_q[i])) & ADDR_MASK;
      if (longint'(ctr_q[i]) + 1 < axis_size(i, er)) is_last = 1'b0;
    end
    res.src_offset = off[OUT_W-1:0];
    res.dst_index  = dst_q;
    res.last       = is_last;
    // carry from the innermost output axis outward
    carry = 1'b1;
    for (k = int'(er) - 1; k >= 0 && carry; k--) begin
      if (longint'(ctr_q[k]) + 1 >= axis_size(k, er)) begin
        ctr_q[k] = '0;
      end else begin
        ctr_q[k] = ctr_q[k] + 1'b1;
        carry = 1'b0;
      end
    end
    dst_q = carry ? '0 : dst_q + 1'b1;
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RANK) cfg_rank_q = data[RANK_W-1:0];
    else if (idx == REG_AXIS_ORDER) cfg_order_q = data[ORDER_W-1:0];
    else if (idx >= REG_DIM_0 && idx <= REG_DIM_5) cfg_dim_q[idx - REG_DIM_0] = data[DIM_REG_W-1:0];
    reg_writes++;
  endtask

  // One input transaction; valid stays high after acceptance until the next call decides
  task automatic send_item(bit restart, bit typed, addr_result_t typed_res);
    addr_result_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = next_address(restart);
    pending_addrs.push_back(typed ? typed_res : res);
    items_sent++;
    if (restart) restarts_sent++;
    @(negedge clk);
  endtask

  // Random configuration: mostly a true permutation over the axes in use, small sizes
  task automatic random_phase(int unsigned n_items);
    int unsigned     perm [MAX_RANK];
    int unsigned     rank_val;
    int unsigned     er;
    int unsigned     i;
    int unsigned     j;
    int unsigned     tmp;
    int unsigned     roll;
    logic [ORDER_W-1:0] order;
    logic [CFG_DATA_W-1:0] dval;
    addr_result_t    none;
    none = '{default: '0};
    rank_val = $urandom_range(0, 7);
    er = (rank_val == 0) ? 1 : (rank_val > MAX_RANK ? MAX_RANK : rank_val);
    for (i = 0; i < MAX_RANK; i++) perm[i] = i;
    for (i = er - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    order = '0;
    for (i = 0; i < MAX_RANK; i++)
      order |= ORDER_W'(i < er ? perm[i] : $urandom_range(0, 7)) << (3 * i);
    if ($urandom_range(0, 99) < 15) order = $urandom_range(0, (1 << ORDER_W) - 1);
    write_reg(REG_RANK, CFG_DATA_W'(rank_val));
    write_reg(REG_AXIS_ORDER, order);
    for (i = 0; i < NUM_DIMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) dval = '0;
      else if (roll < 88) dval = $urandom_range(1, 3);
      else if (roll < 94) dval = CFG_DATA_W'(16'hFFFF);
      else dval = $urandom_range(0, (1 << CFG_DATA_W) - 1);
      write_reg(REG_DIM_0 + CFG_IDX_W'(i), dval);
    end
    // most phases restart; the rest continue the pass under the new sizes
    send_item($urandom_range(0, 99) < 90, 1'b0, none);
    for (i = 1; i < n_items; i++) send_item($urandom_range(0, 99) < 4, 1'b0, none);
  endtask

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.ridx   = idx;
    r.wdata  = data;
    return r;
  endfunction

  function automatic dir_row_t item_row(bit restart);
    dir_row_t r;
    r = '0;
    r.restart = restart;
    return r;
  endfunction

  function automatic dir_row_t typed_row(bit restart, int unsigned off, int unsigned dst, bit last);
    dir_row_t r;
    r = '0;
    r.restart = restart;
    r.typed   = 1'b1;
    r.off     = OUT_W'(off);
    r.dst     = OUT_W'(dst);
    r.last    = last;
    return r;
  endfunction

  // Receiver stall pattern
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle);

  // Result checking against the oldest expectation
  always @(posedge clk) begin
    addr_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_addrs.size() == 0) begin
        report_error($sformatf("result with nothing expected: offset %0h index %0h last %0b",
                               out_src_offset, out_dst_index, out_last));
      end else begin
        exp_res = pending_addrs.pop_front();
        if (out_src_offset !== exp_res.src_offset)
          report_error($sformatf("result %0d src_offset %0h expected %0h",
                                 results_checked, out_src_offset, exp_res.src_offset));
        if (out_dst_index !== exp_res.dst_index)
          report_error($sformatf("result %0d dst_index %0h expected %0h",
                                 results_checked, out_dst_index, exp_res.dst_index));
        if (out_last !== exp_res.last)
          report_error($sformatf("result %0d last %0b expected %0b",
                                 results_checked, out_last, exp_res.last));
        if (exp_res.last) last_seen++;
      end
      results_checked++;
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_addrs.size());
    $display("FAIL tensor_permute_address_gen");
    $finish;
  end

  // Main sequence
  initial begin
    int           r;
    int           random_sent;
    addr_result_t tres;
    for (r = 0; r < NUM_DIMS; r++) cfg_dim_q[r] = DIM_RST;
    for (r = 0; r < MAX_RANK; r++) begin
      ctr_q[r] = '0;
      stride_q[r] = '0;
    end
    dir_table = '{
      // state after reset, then a restart of the single-element identity tensor
      typed_row(1'b0, 0, 0, 1'b1),
      typed_row(1'b1, 0, 0, 1'b1),
      // rank 2 transpose of a 3x2 tensor, run past the wrap
      cfg_row(REG_RANK, 2),
      cfg_row(REG_AXIS_ORDER, 1),
      cfg_row(REG_DIM_0, 3),
      cfg_row(REG_DIM_0 + 3'd1, 2),
      typed_row(1'b1, 0, 0, 1'b0),
      item_row(1'b0), item_row(1'b0), item_row(1'b0),
      item_row(1'b0), item_row(1'b0), item_row(1'b0),
      // size shrinks mid-pass: counter beyond its size carries
      cfg_row(REG_DIM_0, 1),
      item_row(1'b0), item_row(1'b0),
      // rank above the axis count, all source axes out of range, all-ones data
      cfg_row(REG_RANK, 7),
      cfg_row(REG_DIM_5, 18'h3FFFF),
      cfg_row(REG_AXIS_ORDER, 18'h3FFFF),
      typed_row(1'b1, 0, 0, 1'b1),
      // zero size, large sizes, repeated and out-of-range source axes
      cfg_row(REG_DIM_0, 0),
      cfg_row(REG_DIM_0 + 3'd2, 65535),
      cfg_row(REG_DIM_0 + 3'd3, 2),
      cfg_row(REG_DIM_0 + 3'd4, 65535),
      cfg_row(REG_AXIS_ORDER, 198621),
      item_row(1'b1),
      item_row(1'b0), item_row(1'b0), item_row(1'b0), item_row(1'b0),
      // rank zero reads as one axis of size three
      cfg_row(REG_RANK, 0),
      cfg_row(REG_DIM_0, 3),
      cfg_row(REG_AXIS_ORDER, 0),
      typed_row(1'b1, 0, 0, 1'b0),
      typed_row(1'b0, 1, 1, 1'b0),
      typed_row(1'b0, 2, 2, 1'b1),
      typed_row(1'b0, 0, 0, 1'b0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, no idling
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].is_cfg) begin
        write_reg(dir_table[r].ridx, dir_table[r].wdata);
      end else begin
        tres.src_offset = dir_table[r].off;
        tres.dst_index  = dir_table[r].dst;
        tres.last       = dir_table[r].last;
        send_item(dir_table[r].restart, dir_table[r].typed, tres);
      end
    end

    // Random phases: sender idles more lightly first, then the receiver does less, then none
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle = 24;
        recv_idle = 55;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 55;
        recv_idle = 24;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      r = $urandom_range(20, 50);
      random_phase(r);
      random_sent += r;
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);

    $display("covered %0d transactions (%0d restarts) and %0d register writes",
             items_sent, restarts_sent, reg_writes);
    $display("checked %0d results, %0d end-of-pass, %0d errors",
             results_checked, last_seen, error_count);
    if (error_count == 0 && pending_addrs.size() == 0) begin
      $display("PASS tensor_permute_address_gen");
    end else begin
      $display("FAIL tensor_permute_address_gen");
    end
    $finish;
  end

endmodule
